/* hw/rtl/alis_pkg.sv */
// ----------------------------------------------------------------------------
// alis_pkg
// Shared types and constants of the array list block: command and status
// codes, transaction payloads and the controller/datapath interface.
// ----------------------------------------------------------------------------
package alis_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned POS_W     = 5;

  localparam logic [CNT_W-1:0] LIMIT_RST = 5'd16;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] entry_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic    load_insert;
    logic    load_search;
    logic    shift_rd;
    logic    shift_wr;
    logic    write_new;
    logic    srch_rd;
    logic    srch_next;
    logic    emit;
    status_e emit_status;
    logic    emit_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_pos;
    logic full;
    logic list_empty;
    logic shift_more;
    logic match;
    logic srch_more;
  } dp_stat_t;

endpackage

/* hw/rtl/array_list_insert_search.sv */
// ----------------------------------------------------------------------------
// array_list_insert_search
// Ordered list of signed 32-bit values with append, insert and search.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on res_o for one cycle with res_valid_o high, and must be captured
// then, as it cannot be held off. Rejected commands (bad position, full), the
// unused command and a search of an empty list give their result in the cycle
// after acceptance with busy staying low. An append keeps busy high while it
// writes the new entry at the end; an insert at position p first moves the
// entries at p and above up one at a time through the single-port store,
// one read state and one write state per entry. A search keeps busy high
// while it walks from index 0 to a match or the last entry, with one
// registered store read and one compare per entry. res_valid_o rises at the
// same edge at which busy falls, so the result is on res_o in the first idle
// cycle. The capacity limit may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module array_list_insert_search #(
  parameter int unsigned DEPTH = alis_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  alis_pkg::in_t               cmd_i,
  output logic                        res_valid_o,
  output alis_pkg::out_t              res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [alis_pkg::CNT_W-1:0]  cfg_data_i
);

  alis_pkg::dp_cmd_t  dp_cmd;
  alis_pkg::dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  alis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (cmd_i.command),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy      (busy)
  );

  alis_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (cmd_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* hw/rtl/alis_datapath.sv */
// ----------------------------------------------------------------------------
// alis_datapath
// Entry store, entry count, capacity limit, walking pointer and the result
// register of the array list.
// ----------------------------------------------------------------------------
module alis_datapath #(
  parameter int unsigned DEPTH = alis_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  alis_pkg::in_t                in_i,
  input  logic                         cfg_valid_i,
  input  logic [alis_pkg::CNT_W-1:0]   cfg_data_i,
  input  alis_pkg::dp_cmd_t            cmd_i,
  output alis_pkg::dp_stat_t           stat_o,
  output logic                         res_valid_o,
  output alis_pkg::out_t               res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = (AW > alis_pkg::CNT_W) ? AW : alis_pkg::CNT_W;

  logic [alis_pkg::VAL_W-1:0] mem_q [DEPTH];
  logic [alis_pkg::VAL_W-1:0] rdata_q;

  logic [alis_pkg::CNT_W-1:0] count_q, count_d;
  logic [alis_pkg::CNT_W-1:0] limit_q;
  logic [PW-1:0]              ptr_q, ptr_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic [alis_pkg::VAL_W-1:0] val_q, val_d;
  logic                       res_valid_q;
  alis_pkg::out_t             res_q, res_d;

  logic [AW-1:0]              rd_addr, wr_addr;
  logic [alis_pkg::VAL_W-1:0] wr_data;
  logic                       wr_en, rd_en;
  logic [PW:0]                ptr_inc;
  logic                       is_append;

  assign is_append = (alis_pkg::cmd_e'(in_i.command) == alis_pkg::CMD_APPEND);

  // status towards the controller
  assign stat_o.bad_pos    = (alis_pkg::cmd_e'(in_i.command) == alis_pkg::CMD_INSERT) &&
                             (in_i.position > count_q);
  assign stat_o.full       = (count_q >= limit_q) || (32'(count_q) >= 32'(DEPTH));
  assign stat_o.list_empty = (count_q == '0);
  assign stat_o.shift_more = (ptr_q > pos_q);
  assign stat_o.match      = (rdata_q == val_q);
  assign ptr_inc           = {1'b0, ptr_q} + {{PW{1'b0}}, 1'b1};
  assign stat_o.srch_more  = (ptr_inc < (PW+1)'(count_q));

  // store ports
  assign rd_en   = cmd_i.shift_rd | cmd_i.srch_rd;
  assign rd_addr = cmd_i.shift_rd ? AW'(ptr_q - {{(PW-1){1'b0}}, 1'b1}) : ptr_q[AW-1:0];
  assign wr_en   = cmd_i.shift_wr | cmd_i.write_new;
  assign wr_addr = cmd_i.write_new ? pos_q[AW-1:0] : ptr_q[AW-1:0];
  assign wr_data = cmd_i.write_new ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    ptr_d   = ptr_q;
    pos_d   = pos_q;
    val_d   = val_q;
    count_d = count_q;
    if (cmd_i.load_insert) begin
      ptr_d = PW'(count_q);
      pos_d = is_append ? PW'(count_q) : PW'(in_i.position);
      val_d = in_i.value;
    end else if (cmd_i.load_search) begin
      ptr_d = '0;
      val_d = in_i.value;
    end else if (cmd_i.shift_wr) begin
      ptr_d = ptr_q - {{(PW-1){1'b0}}, 1'b1};
    end else if (cmd_i.srch_next) begin
      ptr_d = ptr_inc[PW-1:0];
    end
    if (cmd_i.write_new) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    res_d             = res_q;
    res_d.status      = cmd_i.emit_status;
    res_d.found_index = cmd_i.emit_idx ? ptr_q[alis_pkg::IDX_W-1:0] : '0;
    res_d.entry_count = count_d;
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    val_q <= val_d;
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= alis_pkg::LIMIT_RST;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= cmd_i.emit;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("entry count beyond store depth");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.write_new |=> (count_q == $past(count_q)))
    else $error("entry count moved without a store write");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |-> !stat_o.full)
    else $error("new entry written into a full list");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> (ptr_q > pos_q))
    else $error("entry moved below the insert position");

endmodule

/* hw/rtl/alis_ctrl.sv */
// ----------------------------------------------------------------------------
// alis_ctrl
// Command sequencer: decodes each command, steps the datapath through the
// move-up or search walk and requests the result.
// ----------------------------------------------------------------------------
module alis_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          command_i,
  input  alis_pkg::dp_stat_t  stat_i,
  output alis_pkg::dp_cmd_t   cmd_o,
  output logic                busy
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SHIFT_RD = 5'b00010,
    S_SHIFT_WR = 5'b00100,
    S_SRCH_RD  = 5'b01000,
    S_SRCH_CMP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_status = alis_pkg::ST_DONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (alis_pkg::cmd_e'(command_i))
            alis_pkg::CMD_APPEND, alis_pkg::CMD_INSERT: begin
              if (stat_i.bad_pos) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = alis_pkg::ST_BADPOS;
              end else if (stat_i.full) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = alis_pkg::ST_FULL;
              end else begin
                cmd_o.load_insert = 1'b1;
                state_d           = S_SHIFT_RD;
              end
            end
            alis_pkg::CMD_SEARCH: begin
              if (stat_i.list_empty) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = alis_pkg::ST_NOTFOUND;
              end else begin
                cmd_o.load_search = 1'b1;
                state_d           = S_SRCH_RD;
              end
            end
            default: begin
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end else begin
          // gap is open, drop the new entry in
          cmd_o.write_new = 1'b1;
          cmd_o.emit      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_SRCH_RD: begin
        cmd_o.srch_rd = 1'b1;
        state_d       = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat_i.match) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_idx = 1'b1;
          state_d        = S_IDLE;
        end else if (stat_i.srch_more) begin
          cmd_o.srch_next = 1'b1;
          state_d         = S_SRCH_RD;
        end else begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = alis_pkg::ST_NOTFOUND;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
